[rtl/core/mppt_pkg.sv]
// ----------------------------------------------------------------------------
// mppt_pkg
// Shared types, constants and helpers for the mouse packet position tracker.
// ----------------------------------------------------------------------------
package mppt_pkg;

  // Field and register widths
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned POS_W    = 12;
  localparam int unsigned SIZE_W   = 13;
  localparam int unsigned MARGIN_W = 7;

  // Defaults
  localparam int unsigned CURSOR_MARGIN = 16;
  localparam int unsigned QUEUE_DEPTH   = 2;
  localparam logic [SIZE_W-1:0] RESET_WIDTH  = 13'd640;
  localparam logic [SIZE_W-1:0] RESET_HEIGHT = 13'd480;

  // Header byte bits
  localparam int unsigned HDR_SYNC_BIT = 3;
  localparam int unsigned HDR_LEFT_BIT = 0;

  // Configuration register indexes
  typedef enum logic [0:0] {
    REG_SCREEN_WIDTH  = 1'b0,
    REG_SCREEN_HEIGHT = 1'b1
  } reg_idx_e;

  // Framer phase, one-hot
  typedef enum logic [2:0] {
    PH_HEADER = 3'b001,
    PH_DX     = 3'b010,
    PH_DY     = 3'b100
  } phase_e;

  // One framed packet, handed from the framer to the update stage
  typedef struct packed {
    logic              left;
    logic [BYTE_W-1:0] dx;
    logic [BYTE_W-1:0] dy;
  } pkt_t;

  // One result transaction
  typedef struct packed {
    logic [POS_W-1:0] x;
    logic [POS_W-1:0] y;
    logic             left;
  } res_t;

  // Upper cursor limit: size minus margin, saturated to 0 .. 4095
  function automatic logic [POS_W-1:0] limit_from_size(
    input logic [SIZE_W-1:0]   size,
    input logic [MARGIN_W-1:0] margin
  );
    logic [SIZE_W:0] diff;
    logic [POS_W-1:0] lim;
    diff = {1'b0, size} - {{(SIZE_W+1-MARGIN_W){1'b0}}, margin};
    if (diff[SIZE_W]) begin
      lim = '0;
    end else if (diff[SIZE_W-1]) begin
      lim = '1;
    end else begin
      lim = diff[POS_W-1:0];
    end
    return lim;
  endfunction

endpackage

[rtl/core/mppt_fifo.sv]
// ----------------------------------------------------------------------------
// mppt_fifo
// Small register-based queue with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
module mppt_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == FullCnt);
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Entry storage, no reset
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

[rtl/core/mppt_framer.sv]
// ----------------------------------------------------------------------------
// mppt_framer
// Front end: frames received bytes into header / dx / dy packets and
// resynchronises on the header sync bit.
// ----------------------------------------------------------------------------
module mppt_framer (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        byte_valid_i,
  input  logic [mppt_pkg::BYTE_W-1:0] byte_i,
  output logic                        pkt_valid_o,
  output mppt_pkg::pkt_t              pkt_o
);

  mppt_pkg::phase_e phase_q, phase_d;
  logic [mppt_pkg::BYTE_W-1:0] hdr_q, hdr_d;
  logic [mppt_pkg::BYTE_W-1:0] dx_q, dx_d;

  // Phase sequencing; a header without the sync bit is dropped
  always_comb begin
    phase_d     = phase_q;
    hdr_d       = hdr_q;
    dx_d        = dx_q;
    pkt_valid_o = 1'b0;
    if (byte_valid_i) begin
      case (phase_q)
        mppt_pkg::PH_HEADER: begin
          if (byte_i[mppt_pkg::HDR_SYNC_BIT]) begin
            hdr_d   = byte_i;
            phase_d = mppt_pkg::PH_DX;
          end
        end
        mppt_pkg::PH_DX: begin
          dx_d    = byte_i;
          phase_d = mppt_pkg::PH_DY;
        end
        default: begin
          pkt_valid_o = 1'b1;
          phase_d     = mppt_pkg::PH_HEADER;
        end
      endcase
    end
  end

  assign pkt_o.left = hdr_q[mppt_pkg::HDR_LEFT_BIT];
  assign pkt_o.dx   = dx_q;
  assign pkt_o.dy   = byte_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= mppt_pkg::PH_HEADER;
      hdr_q   <= '0;
      dx_q    <= '0;
    end else begin
      phase_q <= phase_d;
      hdr_q   <= hdr_d;
      dx_q    <= dx_d;
    end
  end

endmodule

[rtl/core/mppt_update.sv]
// ----------------------------------------------------------------------------
// mppt_update
// Back end: applies a packet's deltas to the cursor position and clamps
// each coordinate to its limit.
// ----------------------------------------------------------------------------
module mppt_update (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       pkt_valid_i,
  input  mppt_pkg::pkt_t             pkt_i,
  output logic                       pkt_pop_o,
  input  logic [mppt_pkg::POS_W-1:0] lim_x_i,
  input  logic [mppt_pkg::POS_W-1:0] lim_y_i,
  input  logic                       res_full_i,
  output logic                       res_push_o,
  output mppt_pkg::res_t             res_o
);

  localparam int unsigned SumW = mppt_pkg::POS_W + 2;
  localparam int unsigned ExtW = SumW - mppt_pkg::BYTE_W;

  logic [mppt_pkg::POS_W-1:0] pos_x_q, pos_x_d;
  logic [mppt_pkg::POS_W-1:0] pos_y_q, pos_y_d;
  logic [SumW-1:0] dx_ext, dy_ext, sum_x, sum_y;

  // One packet a cycle while the result queue has room
  assign pkt_pop_o  = pkt_valid_i & ~res_full_i;
  assign res_push_o = pkt_pop_o;

  // Signed sums; y grows downward
  assign dx_ext = {{ExtW{pkt_i.dx[mppt_pkg::BYTE_W-1]}}, pkt_i.dx};
  assign dy_ext = {{ExtW{pkt_i.dy[mppt_pkg::BYTE_W-1]}}, pkt_i.dy};
  assign sum_x  = {2'b00, pos_x_q} + dx_ext;
  assign sum_y  = {2'b00, pos_y_q} - dy_ext;

  // Clamp to 0 .. limit
  always_comb begin
    if (sum_x[SumW-1]) begin
      pos_x_d = '0;
    end else if (sum_x[SumW-2:0] > {1'b0, lim_x_i}) begin
      pos_x_d = lim_x_i;
    end else begin
      pos_x_d = sum_x[mppt_pkg::POS_W-1:0];
    end
    if (sum_y[SumW-1]) begin
      pos_y_d = '0;
    end else if (sum_y[SumW-2:0] > {1'b0, lim_y_i}) begin
      pos_y_d = lim_y_i;
    end else begin
      pos_y_d = sum_y[mppt_pkg::POS_W-1:0];
    end
  end

  assign res_o.x    = pos_x_d;
  assign res_o.y    = pos_y_d;
  assign res_o.left = pkt_i.left;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_x_q <= '0;
      pos_y_q <= '0;
    end else if (pkt_pop_o) begin
      pos_x_q <= pos_x_d;
      pos_y_q <= pos_y_d;
    end
  end

endmodule

[rtl/core/mouse_packet_position_tracker_unit.sv]
// ----------------------------------------------------------------------------
// mouse_packet_position_tracker_unit
// Frames mouse bytes into packets and tracks a clamped cursor position.
// ----------------------------------------------------------------------------
// Channel  | Handshake          | Payload
// ---------+--------------------+--------------------------------------------
// input    | push / full        | rx_byte_i
// result   | empty / pop        | cursor_x_o, cursor_y_o, left_pressed_o
// config   | cfg_we_i           | cfg_index_i, cfg_data_i
//
// One byte is taken every cycle while full is low. The framer writes a packet
// into a two-entry queue on the third byte; the update stage takes one packet
// a cycle while the result queue has room and writes a two-entry result
// queue. The limits are worked out at config write time.
// Reset leaves the cursor at 0,0 with a 640 x 480 screen; full rises only when
// the packet queue is full, and empty stays low while results wait.
// ----------------------------------------------------------------------------
module mouse_packet_position_tracker_unit #(
  parameter int unsigned CursorMargin = mppt_pkg::CURSOR_MARGIN,
  parameter int unsigned QueueDepth   = mppt_pkg::QUEUE_DEPTH
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // Byte input
  input  logic                        push,
  output logic                        full,
  input  logic [mppt_pkg::BYTE_W-1:0] rx_byte_i,
  // Results
  output logic                        empty,
  input  logic                        pop,
  output logic [mppt_pkg::POS_W-1:0]  cursor_x_o,
  output logic [mppt_pkg::POS_W-1:0]  cursor_y_o,
  output logic                        left_pressed_o,
  // Configuration
  input  logic                        cfg_we_i,
  input  mppt_pkg::reg_idx_e          cfg_index_i,
  input  logic [mppt_pkg::SIZE_W-1:0] cfg_data_i
);

  localparam logic [mppt_pkg::MARGIN_W-1:0] Margin = mppt_pkg::MARGIN_W'(CursorMargin);
  localparam int unsigned PktW = $bits(mppt_pkg::pkt_t);
  localparam int unsigned ResW = $bits(mppt_pkg::res_t);

  logic [mppt_pkg::POS_W-1:0] lim_x_q, lim_y_q;
  logic                       byte_acc;
  logic                       fr_valid;
  mppt_pkg::pkt_t             fr_pkt, pq_pkt;
  logic                       pq_full, pq_empty, pq_pop;
  logic                       rq_push, rq_full;
  mppt_pkg::res_t             up_res, rq_res;

  // Limits, stored already reduced by the margin
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lim_x_q <= mppt_pkg::limit_from_size(mppt_pkg::RESET_WIDTH, Margin);
      lim_y_q <= mppt_pkg::limit_from_size(mppt_pkg::RESET_HEIGHT, Margin);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        mppt_pkg::REG_SCREEN_WIDTH: begin
          lim_x_q <= mppt_pkg::limit_from_size(cfg_data_i, Margin);
        end
        mppt_pkg::REG_SCREEN_HEIGHT: begin
          lim_y_q <= mppt_pkg::limit_from_size(cfg_data_i, Margin);
        end
        default: begin
        end
      endcase
    end
  end

  // Front: byte framing
  assign full     = pq_full;
  assign byte_acc = push & ~pq_full;

  mppt_framer u_framer (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_valid_i (byte_acc),
    .byte_i       (rx_byte_i),
    .pkt_valid_o  (fr_valid),
    .pkt_o        (fr_pkt)
  );

  // Packet queue between front and back
  mppt_fifo #(
    .Width (PktW),
    .Depth (QueueDepth)
  ) u_pkt_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fr_valid),
    .data_i  (fr_pkt),
    .full_o  (pq_full),
    .pop_i   (pq_pop),
    .data_o  (pq_pkt),
    .empty_o (pq_empty)
  );

  // Back: position update
  mppt_update u_update (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pkt_valid_i (~pq_empty),
    .pkt_i       (pq_pkt),
    .pkt_pop_o   (pq_pop),
    .lim_x_i     (lim_x_q),
    .lim_y_i     (lim_y_q),
    .res_full_i  (rq_full),
    .res_push_o  (rq_push),
    .res_o       (up_res)
  );

  // Result queue
  mppt_fifo #(
    .Width (ResW),
    .Depth (QueueDepth)
  ) u_res_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (rq_push),
    .data_i  (up_res),
    .full_o  (rq_full),
    .pop_i   (pop),
    .data_o  (rq_res),
    .empty_o (empty)
  );

  assign cursor_x_o     = rq_res.x;
  assign cursor_y_o     = rq_res.y;
  assign left_pressed_o = rq_res.left;

endmodule

[sim/tb_mouse_packet_position_tracker_unit.sv]
// ----------------------------------------------------------------------------
// tb_mouse_packet_position_tracker_unit
// Streams mouse bytes into the tracker and checks every cursor update. The
// bench keeps its own copy of the packet framing, cursor position and screen
// limits, works out each position when the completing byte goes in, and
// compares the results in order. Runs a directed opening, then phases with
// several screen sizes and idle patterns, one with a long result hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_mouse_packet_position_tracker_unit;

  import mppt_pkg::*;

  localparam int unsigned NUM_PHASES   = 8;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned STALL_LIMIT   = 5000;
  localparam int          POS_CEILING   = 4095;

  // --------------------------------------------------------------------------
  // Cursor predictor and store of expected positions
  // --------------------------------------------------------------------------
  class cursor_scoreboard;
    phase_e               frame_phase;
    logic [BYTE_W-1:0]    header_q;
    logic [BYTE_W-1:0]    dx_q;
    logic [POS_W-1:0]     pos_x;
    logic [POS_W-1:0]     pos_y;
    logic [SIZE_W-1:0]    width;
    logic [SIZE_W-1:0]    height;
    res_t                 expected_positions[$];
    int                   errors;
    int                   framed_bytes;
    int                   packets_checked;
    int                   reg_writes;

    function new();
      frame_phase     = PH_HEADER;
      header_q        = '0;
      dx_q            = '0;
      pos_x           = '0;
      pos_y           = '0;
      width           = RESET_WIDTH;
      height          = RESET_HEIGHT;
      errors          = 0;
      framed_bytes    = 0;
      packets_checked = 0;
      reg_writes      = 0;
    endfunction

    // Size minus margin, held within what a 12-bit position can hold
    function int size_limit(logic [SIZE_W-1:0] size);
      int lim;
      lim = int'(size) - int'(CURSOR_MARGIN);
      if (lim < 0) lim = 0;
      if (lim > POS_CEILING) lim = POS_CEILING;
      return lim;
    endfunction

    function logic [POS_W-1:0] clamp_pos(int v, int lim);
      if (v < 0) v = 0;
      if (v > lim) v = lim;
      return v[POS_W-1:0];
    endfunction

    function void note_reg(reg_idx_e idx, logic [SIZE_W-1:0] value);
      reg_writes++;
      case (idx)
        REG_SCREEN_WIDTH:  width  = value;
        REG_SCREEN_HEIGHT: height = value;
        default: ;
      endcase
    endfunction

    // One accepted byte: frame it, and on the third byte move the cursor
    function void note_byte(logic [BYTE_W-1:0] b);
      int   dxs;
      int   dys;
      res_t upd;
      case (frame_phase)
        PH_HEADER: begin
          // headers without the sync bit are dropped
          if (b[HDR_SYNC_BIT]) begin
            header_q     = b;
            frame_phase  = PH_DX;
            framed_bytes++;
          end
        end
        PH_DX: begin
          dx_q        = b;
          frame_phase = PH_DY;
          framed_bytes++;
        end
        default: begin
          frame_phase = PH_HEADER;
          framed_bytes++;
          dxs      = int'($signed(dx_q));
          dys      = int'($signed(b));
          pos_x    = clamp_pos(int'(pos_x) + dxs, size_limit(width));
          pos_y    = clamp_pos(int'(pos_y) - dys, size_limit(height));
          upd.x    = pos_x;
          upd.y    = pos_y;
          upd.left = header_q[HDR_LEFT_BIT];
          expected_positions.push_back(upd);
        end
      endcase
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (expected_positions.size() == 0) begin
        $error("unexpected result transaction: x %0d y %0d left %0b",
               got.x, got.y, got.left);
        errors++;
        return;
      end
      want = expected_positions.pop_front();
      packets_checked++;
      if (got.x !== want.x) begin
        $error("cursor_x mismatch: expected %0d, got %0d", want.x, got.x);
        errors++;
      end
      if (got.y !== want.y) begin
        $error("cursor_y mismatch: expected %0d, got %0d", want.y, got.y);
        errors++;
      end
      if (got.left !== want.left) begin
        $error("left_pressed mismatch: expected %0b, got %0b", want.left, got.left);
        errors++;
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and block
  // --------------------------------------------------------------------------
  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               push;
  logic               full;
  logic [BYTE_W-1:0]  rx_byte_i;
  logic               empty;
  logic               pop;
  logic [POS_W-1:0]   cursor_x_o;
  logic [POS_W-1:0]   cursor_y_o;
  logic               left_pressed_o;
  logic               cfg_we_i;
  reg_idx_e           cfg_index_i;
  logic [SIZE_W-1:0]  cfg_data_i;

  cursor_scoreboard   sb = new();
  int                 send_idle_pct  = 0;
  int                 recv_stall_pct = 0;
  bit                 hold_req       = 1'b0;
  int                 quiet_cycles   = 0;

  always #2 clk_i = ~clk_i;

  mouse_packet_position_tracker_unit u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .rx_byte_i      (rx_byte_i),
    .empty          (empty),
    .pop            (pop),
    .cursor_x_o     (cursor_x_o),
    .cursor_y_o     (cursor_y_o),
    .left_pressed_o (left_pressed_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  // --------------------------------------------------------------------------
  // Monitor: samples pre-edge values, so ordering within the step is moot
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) sb.note_reg(cfg_index_i, cfg_data_i);
      if ((push && !full) || (pop && !empty)) quiet_cycles = 0;
      else quiet_cycles++;
      if (push && !full) sb.note_byte(rx_byte_i);
      if (pop && !empty) sb.check_result({cursor_x_o, cursor_y_o, left_pressed_o});
      // watchdog on cycles with no transaction at all
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
        $display("tb_mouse_packet_position_tracker_unit: done, errors");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result side: random stalls, plus a long hold-off on request
  // --------------------------------------------------------------------------
  initial begin
    pop <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else begin
        pop <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Byte side
  // --------------------------------------------------------------------------
  task automatic send_byte(input logic [BYTE_W-1:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push      <= 1'b1;
    rx_byte_i <= b;
    do @(posedge clk_i); while (full);
  endtask

  task automatic send_packet(input logic [BYTE_W-1:0] hdr, dx, dy);
    send_byte(hdr);
    send_byte(dx);
    send_byte(dy);
  endtask

  // Lower push and wait until every expected position has come back
  task automatic drain();
    push <= 1'b0;
    @(posedge clk_i);
    while (sb.expected_positions.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [SIZE_W-1:0] value);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // A delta pushed one way for drift, or anything at all
  function automatic logic [BYTE_W-1:0] pick_delta(bit drift, bit upward);
    if (!drift) return BYTE_W'($urandom_range(0, 255));
    if (upward) return BYTE_W'($urandom_range(64, 127));
    return BYTE_W'($urandom_range(128, 192));
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  int unsigned phase_width[NUM_PHASES]  = '{16, 4096, 0, 8191, 17, 0, 4111, 0};
  int unsigned phase_height[NUM_PHASES] = '{16, 4096, 15, 4112, 8191, 0, 100, 0};
  bit          phase_rand[NUM_PHASES]   = '{0, 0, 0, 0, 0, 1, 0, 1};
  int unsigned phase_items[NUM_PHASES]  = '{90, 200, 90, 110, 90, 100, 90, 100};
  int          send_pct[4] = '{0, 60, 0, 22};
  int          recv_pct[4] = '{0, 0, 60, 22};

  initial begin
    logic [SIZE_W-1:0] w;
    logic [SIZE_W-1:0] h;
    int                target;
    bit                up_x;
    bit                up_y;
    bit                drift;

    push        <= 1'b0;
    rx_byte_i   <= '0;
    cfg_we_i    <= 1'b0;
    cfg_index_i <= REG_SCREEN_WIDTH;
    cfg_data_i  <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: dropped headers, extreme deltas, clamping at 0, both buttons
    send_byte(8'h00);
    send_byte(8'hF7);
    send_packet(8'h09, 8'h7F, 8'h80);
    send_packet(8'h08, 8'h80, 8'h7F);
    send_packet(8'hFF, 8'hFF, 8'h01);
    send_packet(8'h08, 8'h00, 8'h00);
    send_byte(8'h37);
    send_packet(8'hF8, 8'h08, 8'hF7);
    send_packet(8'h0E, 8'h7F, 8'h80);

    // Phases of screen setups and idle patterns
    for (int p = 0; p < NUM_PHASES; p++) begin
      w = SIZE_W'(phase_width[p]);
      h = SIZE_W'(phase_height[p]);
      if (phase_rand[p]) begin
        w = SIZE_W'($urandom_range(16, 4096));
        h = SIZE_W'($urandom_range(16, 4096));
      end
      write_reg(REG_SCREEN_WIDTH, w);
      write_reg(REG_SCREEN_HEIGHT, h);
      send_idle_pct  = send_pct[p % 4];
      recv_stall_pct = recv_pct[p % 4];
      // big screen phase: block the results so the queues fill up
      if (p == 1) hold_req = 1'b1;
      up_x   = 1'($urandom_range(1));
      up_y   = 1'($urandom_range(1));
      target = sb.framed_bytes + int'(phase_items[p]);
      while (sb.framed_bytes < target) begin
        if ($urandom_range(99) < 10) begin
          send_byte(BYTE_W'($urandom_range(0, 255)));
        end else begin
          drift = ($urandom_range(99) < 75);
          send_packet({4'($urandom_range(15)), 1'b1, 3'($urandom_range(7))},
                      pick_delta(drift, up_x), pick_delta(drift, !up_y));
        end
      end
    end

    drain();
    if (sb.expected_positions.size() != 0) begin
      $error("%0d expected positions never arrived", sb.expected_positions.size());
      sb.errors++;
    end
    $display("Run covered %0d framed bytes and %0d cursor updates, %0d register writes,",
             sb.framed_bytes, sb.packets_checked, sb.reg_writes);
    $display("screens from below the margin to beyond 4096, idle and stall patterns, one hold-off");
    if (sb.errors == 0) begin
      $display("tb_mouse_packet_position_tracker_unit: done, clean");
    end else begin
      $display("tb_mouse_packet_position_tracker_unit: done, errors");
    end
    $finish;
  end

endmodule
